>>> rtl/gbc_pkg.sv
// Shared widths, codes and constants of the gyro bias calibrator.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package gbc_pkg;

    // Field widths
    localparam int GYRO_W     = 16;
    localparam int LIMIT_W    = 16;
    localparam int YAW_W      = 21;
    localparam int TEMP_W     = 9;
    localparam int PCT_W      = 7;
    localparam int BIAS_W     = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Default calibration length in samples
    localparam int SAMPLE_COUNT_DEF = 50;

    // Register reset values
    localparam logic [LIMIT_W-1:0] MOTION_LIMIT_RST = 16'd3932;

    // Request opcodes
    localparam logic OPC_SAMPLE = 1'b0;
    localparam logic OPC_START  = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTION_LIMIT = 1'b0,
        CFG_YAW_INVERT   = 1'b1
    } t_cfg_idx;

    // Calibration phase codes as reported on the result
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RUN  = 2'd1,
        PH_DONE = 2'd2,
        PH_FAIL = 2'd3
    } t_phase;

    // Calibration status handed from the controller to the datapath
    typedef struct packed {
        t_phase phase;
        logic   finish;
    } t_cal_stat;

    // Temperature conversion: (10 * raw + 124202) / 3400
    localparam int TEMP_MUL    = 10;
    localparam int TEMP_ADD    = 124202;
    localparam int TEMP_DIV    = 3400;
    localparam int TEMP_NUM_W  = 21;
    localparam int TEMP_MAG_W  = 19;

    // Progress percent
    localparam int PCT_SCALE   = 100;
    localparam int PCT_SCALE_W = 7;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // Bias saturation limits
    localparam logic signed [BIAS_W-1:0] BIAS_MAX = {1'b0, {(BIAS_W-1){1'b1}}};
    localparam logic signed [BIAS_W-1:0] BIAS_MIN = {1'b1, {(BIAS_W-1){1'b0}}};
    localparam int BIAS_POS_LIM = 65535;
    localparam int BIAS_NEG_LIM = 65536;

endpackage

>>> rtl/gbc_if.sv
// Valid/ready channel interfaces for sample requests and results.
// Depends on gbc_pkg for field widths.
`timescale 1ns / 1ps

interface gbc_in_if;
    logic                               valid;
    logic                               ready;
    logic                               opcode;
    logic signed [gbc_pkg::GYRO_W-1:0]  gyro_x;
    logic signed [gbc_pkg::GYRO_W-1:0]  gyro_y;
    logic signed [gbc_pkg::GYRO_W-1:0]  gyro_z;
    logic signed [gbc_pkg::GYRO_W-1:0]  temp_raw;

    modport source (output valid, opcode, gyro_x, gyro_y, gyro_z, temp_raw, input ready);
    modport sink   (input valid, opcode, gyro_x, gyro_y, gyro_z, temp_raw, output ready);
endinterface

interface gbc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [gbc_pkg::YAW_W-1:0]   yaw_rate;
    logic signed [gbc_pkg::TEMP_W-1:0]  temp_c;
    logic        [1:0]                  cal_phase;
    logic        [gbc_pkg::PCT_W-1:0]   cal_percent;
    logic signed [gbc_pkg::BIAS_W-1:0]  z_bias;

    modport source (output valid, yaw_rate, temp_c, cal_phase, cal_percent, z_bias,
                    input ready);
    modport sink   (input valid, yaw_rate, temp_c, cal_phase, cal_percent, z_bias,
                    output ready);
endinterface

>>> rtl/gbc_const_div.sv
// Unsigned divide by a constant: reciprocal multiply, one-step correction.
// Product is registered inside; corrected quotient is combinational after it.
`timescale 1ns / 1ps

module gbc_const_div #(
    parameter int DIVIDEND_W = 19,
    parameter int DIVISOR    = 3400
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic [DIVIDEND_W-1:0] i_num,
    output logic [DIVIDEND_W-1:0] o_quot
);

    // Dividend stays below 2^SHIFT, so the estimate is low by at most one
    localparam int SHIFT = DIVIDEND_W;
    localparam int PROD_W = 2 * DIVIDEND_W;
    localparam logic [SHIFT-1:0]      RECIP = SHIFT'((2 ** SHIFT) / DIVISOR);
    localparam logic [DIVIDEND_W-1:0] DIV_V = DIVIDEND_W'(DIVISOR);

    logic [PROD_W-1:0]     r_prod;
    logic [DIVIDEND_W-1:0] r_num;
    logic [PROD_W-1:0]     n_prod;
    logic [DIVIDEND_W-1:0] q_est;
    logic [DIVIDEND_W-1:0] rem;

    assign n_prod = PROD_W'(i_num) * PROD_W'(RECIP);

    // Hold product and dividend for the correction step
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
            r_num  <= i_num;
        end
    end

    // Bump the estimate when the remainder reaches the divisor
    assign q_est  = r_prod[PROD_W-1:SHIFT];
    assign rem    = r_num - DIVIDEND_W'(q_est * DIV_V);
    assign o_quot = (rem >= DIV_V) ? q_est + DIVIDEND_W'(1) : q_est;

endmodule

>>> rtl/gbc_cal_ctrl.sv
// Calibration controller: phase, sample count and Z accumulator.
// Depends on gbc_pkg for opcodes, phase codes and the status struct.
`timescale 1ns / 1ps

module gbc_cal_ctrl #(
    parameter int SAMPLE_COUNT = gbc_pkg::SAMPLE_COUNT_DEF,
    parameter int CNT_W        = $clog2(SAMPLE_COUNT + 1),
    parameter int SUM_W        = gbc_pkg::GYRO_W + $clog2(SAMPLE_COUNT)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic                               i_opcode,
    input  logic signed [gbc_pkg::GYRO_W-1:0]  i_gyro_x,
    input  logic signed [gbc_pkg::GYRO_W-1:0]  i_gyro_y,
    input  logic signed [gbc_pkg::GYRO_W-1:0]  i_gyro_z,
    input  logic        [gbc_pkg::LIMIT_W-1:0] i_motion_limit,
    output gbc_pkg::t_cal_stat                 o_stat,
    output logic signed [SUM_W-1:0]            o_sum,
    output logic        [CNT_W-1:0]            o_count
);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLE_COUNT);
    localparam int MAG_W = gbc_pkg::GYRO_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE,
        ST_FAIL
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic signed [SUM_W-1:0] r_sum,   n_sum;
    logic                    finish;
    logic                    over;
    logic [MAG_W-1:0]        lim;

    function automatic logic [MAG_W-1:0] f_abs(input logic signed [gbc_pkg::GYRO_W-1:0] v);
        logic signed [MAG_W-1:0] w;
        w = MAG_W'(v);
        f_abs = w[MAG_W-1] ? MAG_W'(-w) : MAG_W'(w);
    endfunction

    // Strict compare: a magnitude equal to the limit passes
    assign lim  = {1'b0, i_motion_limit};
    assign over = (f_abs(i_gyro_x) > lim) || (f_abs(i_gyro_y) > lim) ||
                  (f_abs(i_gyro_z) > lim);

    // Advance calibration on each accepted request
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_sum   = r_sum;
        finish  = 1'b0;
        if (i_accept) begin
            if (i_opcode == gbc_pkg::OPC_START) begin
                n_state = ST_RUN;
                n_count = '0;
                n_sum   = '0;
            end else if (r_state == ST_RUN) begin
                if (over) begin
                    n_state = ST_FAIL;
                end else begin
                    n_sum   = r_sum + SUM_W'(i_gyro_z);
                    n_count = r_count + CNT_W'(1);
                    if (n_count >= LAST) begin
                        n_state = ST_DONE;
                        finish  = 1'b1;
                    end
                end
            end
        end
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // Report the state as left by this request
    always_comb begin
        unique case (n_state)
            ST_IDLE: o_stat.phase = gbc_pkg::PH_IDLE;
            ST_RUN:  o_stat.phase = gbc_pkg::PH_RUN;
            ST_DONE: o_stat.phase = gbc_pkg::PH_DONE;
            ST_FAIL: o_stat.phase = gbc_pkg::PH_FAIL;
        endcase
        o_stat.finish = finish;
    end

    assign o_sum   = n_sum;
    assign o_count = n_count;

endmodule

>>> rtl/gyro_bias_calibrator.sv
// Top level of the gyro Z bias calibrator: controller, dividers, result pipeline.
// Depends on gbc_pkg, gbc_if, gbc_cal_ctrl and gbc_const_div.
//
//   port      dir  kind        contents
//   i_in      in   valid/ready opcode, gyro_x, gyro_y, gyro_z, temp_raw
//   o_out     out  valid/ready yaw_rate, temp_c, cal_phase, cal_percent, z_bias
//   i_cfg_*   in   write only  motion_limit (index 0), yaw_invert (index 1)
//
// One request per cycle unless stalled; each passes four registers in order
// (stage 1, stage 2 with divider products, stage 3, output) to reach o_out.
// The controller accumulates and compares combinationally on the taken request.
// Synchronous active-low reset clears phase, count, sum, bias and all valid bits.
// Each stage moves when the stage after it is empty or moving, so bubbles fill
// while a result waits; i_in.ready drops only when every stage is full and stalled.
`timescale 1ns / 1ps

module gyro_bias_calibrator #(
    parameter int SAMPLE_COUNT = gbc_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    gbc_in_if.sink                                i_in,
    gbc_out_if.source                             o_out
);

    localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
    localparam int SUM_W = gbc_pkg::GYRO_W + $clog2(SAMPLE_COUNT);
    localparam int BQ_W  = SUM_W + 4;
    localparam int PN_W  = CNT_W + gbc_pkg::PCT_SCALE_W;
    localparam int TN_W  = gbc_pkg::TEMP_NUM_W;
    localparam int TM_W  = gbc_pkg::TEMP_MAG_W;

    // Configuration registers
    logic [gbc_pkg::LIMIT_W-1:0] r_motion_limit;
    logic                        r_yaw_invert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_limit <= gbc_pkg::MOTION_LIMIT_RST;
            r_yaw_invert   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (gbc_pkg::t_cfg_idx'(i_cfg_idx))
                gbc_pkg::CFG_MOTION_LIMIT: r_motion_limit <= i_cfg_data[gbc_pkg::LIMIT_W-1:0];
                gbc_pkg::CFG_YAW_INVERT:   r_yaw_invert   <= i_cfg_data[0];
            endcase
        end
    end

    // Stage advance: each stage loads when it is empty or its successor loads
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_o_valid;
    logic ld_o, ld3, ld2, ld1, in_acc;

    assign ld_o   = !r_o_valid || o_out.ready;
    assign ld3    = !r_s3_valid || ld_o;
    assign ld2    = !r_s2_valid || ld3;
    assign ld1    = !r_s1_valid || ld2;
    assign in_acc = i_in.valid && ld1;
    assign i_in.ready = ld1;

    // Calibration controller
    gbc_pkg::t_cal_stat      cal_stat;
    logic signed [SUM_W-1:0] cal_sum;
    logic [CNT_W-1:0]        cal_count;

    gbc_cal_ctrl #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .CNT_W        (CNT_W),
        .SUM_W        (SUM_W)
    ) u_cal_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_acc),
        .i_opcode       (i_in.opcode),
        .i_gyro_x       (i_in.gyro_x),
        .i_gyro_y       (i_in.gyro_y),
        .i_gyro_z       (i_in.gyro_z),
        .i_motion_limit (r_motion_limit),
        .o_stat         (cal_stat),
        .o_sum          (cal_sum),
        .o_count        (cal_count)
    );

    // Split sum and temperature numerator into sign and magnitude
    logic [SUM_W-1:0]        sum_abs;
    logic signed [TN_W-1:0]  tnum;
    logic [TM_W-1:0]         tnum_abs;

    assign sum_abs  = cal_sum[SUM_W-1] ? SUM_W'(-cal_sum) : SUM_W'(cal_sum);
    assign tnum     = (TN_W'(i_in.temp_raw) <<< 3) + (TN_W'(i_in.temp_raw) <<< 1)
                    + TN_W'(gbc_pkg::TEMP_ADD);
    assign tnum_abs = tnum[TN_W-1] ? TM_W'(-tnum) : TM_W'(tnum);

    // Stage 1: request as seen by the controller
    logic                               r_s1_cmd;
    gbc_pkg::t_cal_stat                 r_s1_stat;
    logic                               r_s1_sum_neg;
    logic                               r_s1_temp_neg;
    logic signed [gbc_pkg::GYRO_W-1:0]  r_s1_gz;
    logic [BQ_W-1:0]                    r_s1_bias_num;
    logic [TM_W-1:0]                    r_s1_temp_num;
    logic [PN_W-1:0]                    r_s1_pct_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (ld1) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_s1_cmd      <= (i_in.opcode == gbc_pkg::OPC_START);
            r_s1_stat     <= cal_stat;
            r_s1_sum_neg  <= cal_sum[SUM_W-1];
            r_s1_temp_neg <= tnum[TN_W-1];
            r_s1_gz       <= i_in.gyro_z;
            r_s1_bias_num <= {sum_abs, 4'b0000};
            r_s1_temp_num <= tnum_abs;
            r_s1_pct_num  <= PN_W'(cal_count) * PN_W'(gbc_pkg::PCT_SCALE);
        end
    end

    // Constant dividers, product registered on the stage 2 load
    logic [BQ_W-1:0] q_bias;
    logic [TM_W-1:0] q_temp;
    logic [PN_W-1:0] q_pct;

    gbc_const_div #(.DIVIDEND_W(BQ_W), .DIVISOR(SAMPLE_COUNT)) u_div_bias (
        .i_clk (i_clk), .i_load (ld2), .i_num (r_s1_bias_num), .o_quot (q_bias)
    );

    gbc_const_div #(.DIVIDEND_W(TM_W), .DIVISOR(gbc_pkg::TEMP_DIV)) u_div_temp (
        .i_clk (i_clk), .i_load (ld2), .i_num (r_s1_temp_num), .o_quot (q_temp)
    );

    gbc_const_div #(.DIVIDEND_W(PN_W), .DIVISOR(SAMPLE_COUNT)) u_div_pct (
        .i_clk (i_clk), .i_load (ld2), .i_num (r_s1_pct_num), .o_quot (q_pct)
    );

    // Stage 2: control alongside the divider products
    logic                               r_s2_cmd;
    gbc_pkg::t_cal_stat                 r_s2_stat;
    logic                               r_s2_sum_neg;
    logic                               r_s2_temp_neg;
    logic signed [gbc_pkg::GYRO_W-1:0]  r_s2_gz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (ld2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_s2_cmd      <= r_s1_cmd;
            r_s2_stat     <= r_s1_stat;
            r_s2_sum_neg  <= r_s1_sum_neg;
            r_s2_temp_neg <= r_s1_temp_neg;
            r_s2_gz       <= r_s1_gz;
        end
    end

    // Sign and saturate the bias; sign the temperature (zero on start); pick percent
    logic signed [gbc_pkg::BIAS_W-1:0] n_bias;
    logic signed [gbc_pkg::TEMP_W-1:0] n_temp;
    logic [gbc_pkg::PCT_W-1:0]         n_pct;

    always_comb begin
        if (r_s2_sum_neg) begin
            if (q_bias > BQ_W'(gbc_pkg::BIAS_NEG_LIM)) begin
                n_bias = gbc_pkg::BIAS_MIN;
            end else begin
                n_bias = -(gbc_pkg::BIAS_W'(q_bias));
            end
        end else begin
            if (q_bias > BQ_W'(gbc_pkg::BIAS_POS_LIM)) begin
                n_bias = gbc_pkg::BIAS_MAX;
            end else begin
                n_bias = gbc_pkg::BIAS_W'(q_bias);
            end
        end
    end

    always_comb begin
        if (r_s2_cmd) begin
            n_temp = '0;
        end else if (r_s2_temp_neg) begin
            n_temp = -(gbc_pkg::TEMP_W'(q_temp));
        end else begin
            n_temp = gbc_pkg::TEMP_W'(q_temp);
        end
    end

    always_comb begin
        unique case (r_s2_stat.phase)
            gbc_pkg::PH_RUN:  n_pct = gbc_pkg::PCT_W'(q_pct);
            gbc_pkg::PH_DONE: n_pct = gbc_pkg::PCT_FULL;
            gbc_pkg::PH_IDLE,
            gbc_pkg::PH_FAIL: n_pct = '0;
        endcase
    end

    // Stage 3: bias register updates as a finishing sample passes
    logic                               r_s3_cmd;
    gbc_pkg::t_phase                    r_s3_phase;
    logic signed [gbc_pkg::GYRO_W-1:0]  r_s3_gz;
    logic signed [gbc_pkg::TEMP_W-1:0]  r_s3_temp;
    logic [gbc_pkg::PCT_W-1:0]          r_s3_pct;
    logic signed [gbc_pkg::BIAS_W-1:0]  r_bias;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_bias     <= '0;
        end else begin
            if (ld3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (ld3 && r_s2_valid && r_s2_stat.finish) begin
                r_bias <= n_bias;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r_s3_cmd   <= r_s2_cmd;
            r_s3_phase <= r_s2_stat.phase;
            r_s3_gz    <= r_s2_gz;
            r_s3_temp  <= n_temp;
            r_s3_pct   <= n_pct;
        end
    end

    // Yaw rate from the bias as left by this same request
    logic signed [gbc_pkg::YAW_W-1:0] yaw_raw;
    logic signed [gbc_pkg::YAW_W-1:0] n_yaw;

    assign yaw_raw = (gbc_pkg::YAW_W'(r_s3_gz) <<< 4) - gbc_pkg::YAW_W'(r_bias);

    always_comb begin
        if (r_s3_cmd) begin
            n_yaw = '0;
        end else if (r_yaw_invert) begin
            n_yaw = -yaw_raw;
        end else begin
            n_yaw = yaw_raw;
        end
    end

    // Output register
    logic signed [gbc_pkg::YAW_W-1:0]  r_o_yaw;
    logic signed [gbc_pkg::TEMP_W-1:0] r_o_temp;
    gbc_pkg::t_phase                   r_o_phase;
    logic [gbc_pkg::PCT_W-1:0]         r_o_pct;
    logic signed [gbc_pkg::BIAS_W-1:0] r_o_bias;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ld_o) begin
            r_o_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_o) begin
            r_o_yaw   <= n_yaw;
            r_o_temp  <= r_s3_temp;
            r_o_phase <= r_s3_phase;
            r_o_pct   <= r_s3_pct;
            r_o_bias  <= r_bias;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.yaw_rate    = r_o_yaw;
    assign o_out.temp_c      = r_o_temp;
    assign o_out.cal_phase   = r_o_phase;
    assign o_out.cal_percent = r_o_pct;
    assign o_out.z_bias      = r_o_bias;

`ifndef SYNTHESIS
    // A taken request always lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted request did not reach stage 1");

    // A done result reports full progress
    a_done_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.cal_phase == gbc_pkg::PH_DONE))
            |-> (o_out.cal_percent == gbc_pkg::PCT_FULL))
        else $error("done result without full progress");

    // Bias moves only when a finishing sample passes stage 3
    a_bias_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_bias) |-> $past(ld3 && r_s2_valid && r_s2_stat.finish))
        else $error("bias changed without a finishing sample");
`endif

endmodule

>>> verif/gyro_bias_calibrator_test.sv
// Self-checking test of gyro_bias_calibrator: directed and random sample streams,
// predicted per request and compared field by field. Depends on gbc_pkg and gbc_if.
`timescale 1ns / 1ps

module gyro_bias_calibrator_test;

    localparam int CAL_LEN     = 50;
    localparam int TEMP_GAIN   = 10;
    localparam int TEMP_BASE   = 124202;
    localparam int TEMP_STEP   = 3400;
    localparam int BIAS_TOP    = 65535;
    localparam int BIAS_BOTTOM = -65536;
    localparam int GYRO_TOP    = 32767;
    localparam int GYRO_BOTTOM = -32768;
    localparam int LONG_HOLD   = 200;
    localparam int SETTLE      = 8;
    localparam int MAX_LINES   = 40;

    typedef struct {
        logic                              opcode;
        logic signed [gbc_pkg::GYRO_W-1:0] gx;
        logic signed [gbc_pkg::GYRO_W-1:0] gy;
        logic signed [gbc_pkg::GYRO_W-1:0] gz;
        logic signed [gbc_pkg::GYRO_W-1:0] temp;
    } t_gyro_req;

    typedef struct {
        logic signed [gbc_pkg::YAW_W-1:0]  yaw;
        logic signed [gbc_pkg::TEMP_W-1:0] temp_c;
        gbc_pkg::t_phase                   phase;
        logic [gbc_pkg::PCT_W-1:0]         pct;
        logic signed [gbc_pkg::BIAS_W-1:0] bias;
    } t_gyro_reading;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    gbc_pkg::t_cfg_idx              cfg_idx;
    logic [gbc_pkg::CFG_DATA_W-1:0] cfg_data;

    gbc_in_if  req_ch ();
    gbc_out_if res_ch ();

    gyro_bias_calibrator #(.SAMPLE_COUNT(CAL_LEN)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (req_ch),
        .o_out      (res_ch)
    );

    // Requests waiting to be offered and readings waiting to come back
    t_gyro_req     pending_requests[$];
    t_gyro_reading due_readings[$];

    // Shadow configuration and calibration state
    int              motion_lim_cfg;
    bit              invert_cfg;
    gbc_pkg::t_phase track_phase;
    int              taken_samples;
    int              z_total;
    int              z_offset;

    t_gyro_req live_req;
    int        accepted_cnt;
    int        queued_cnt;
    int        mismatch_cnt;
    int        send_gap;
    int        send_calm;
    int        recv_stall;
    int        recv_calm;
    int        hold_left;
    int        next_hold_at;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop in case the handshake hangs
    initial begin
        #5_000_000;
        $display("gyro_bias_calibrator test failed");
        $finish;
    end

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the shadow calibration by one request and return its reading
    function automatic t_gyro_reading calibrate_step(t_gyro_req rq);
        t_gyro_reading rs;
        int gx, gy, gz, tr, b, yaw, temp, pct;
        yaw  = 0;
        temp = 0;
        pct  = 0;
        if (rq.opcode == gbc_pkg::OPC_START) begin
            track_phase   = gbc_pkg::PH_RUN;
            taken_samples = 0;
            z_total       = 0;
        end else begin
            gx = int'(rq.gx);
            gy = int'(rq.gy);
            gz = int'(rq.gz);
            tr = int'(rq.temp);
            if (track_phase == gbc_pkg::PH_RUN) begin
                if (magnitude(gx) > motion_lim_cfg || magnitude(gy) > motion_lim_cfg ||
                    magnitude(gz) > motion_lim_cfg) begin
                    track_phase = gbc_pkg::PH_FAIL;
                end else begin
                    z_total += gz;
                    taken_samples++;
                    if (taken_samples >= CAL_LEN) begin
                        b = (z_total * 16) / CAL_LEN;
                        if (b > BIAS_TOP) b = BIAS_TOP;
                        if (b < BIAS_BOTTOM) b = BIAS_BOTTOM;
                        z_offset    = b;
                        track_phase = gbc_pkg::PH_DONE;
                    end
                end
            end
            yaw = gz * 16 - z_offset;
            if (invert_cfg) yaw = -yaw;
            temp = (TEMP_GAIN * tr + TEMP_BASE) / TEMP_STEP;
        end
        if (track_phase == gbc_pkg::PH_RUN) pct = taken_samples * 100 / CAL_LEN;
        else if (track_phase == gbc_pkg::PH_DONE) pct = 100;
        rs.yaw    = gbc_pkg::YAW_W'(yaw);
        rs.temp_c = gbc_pkg::TEMP_W'(temp);
        rs.phase  = track_phase;
        rs.pct    = gbc_pkg::PCT_W'(pct);
        rs.bias   = gbc_pkg::BIAS_W'(z_offset);
        return rs;
    endfunction

    // Mostly short gaps, a few long ones, and stretches with none
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 3) begin
            calm_left = int'($urandom_range(20, 80));
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return int'($urandom_range(1, 3));
        if (r < 97) return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 40));
    endfunction

    function automatic int rand_in(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic report_mismatch(string what);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_LINES) $display("%0t mismatch: %s", $realtime, what);
    endtask

    // Request driver: hold each request until taken, then apply a gap
    always @(posedge i_clk) begin : drive_requests
        t_gyro_req rq;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap     <= 0;
            accepted_cnt <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                due_readings.push_back(calibrate_step(live_req));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    req_ch.valid <= 1'b0;
                    send_gap     <= send_gap - 1;
                end else if (pending_requests.size() > 0) begin
                    rq = pending_requests.pop_front();
                    live_req        <= rq;
                    req_ch.opcode   <= rq.opcode;
                    req_ch.gyro_x   <= rq.gx;
                    req_ch.gyro_y   <= rq.gy;
                    req_ch.gyro_z   <= rq.gz;
                    req_ch.temp_raw <= rq.temp;
                    req_ch.valid    <= 1'b1;
                    send_gap        <= pick_gap(send_calm);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each reading, then decide ready for the next cycle
    always @(posedge i_clk) begin : check_readings
        t_gyro_reading want;
        int gap;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_stall   <= 0;
            hold_left    <= 0;
            next_hold_at <= 150;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (due_readings.size() == 0) begin
                    report_mismatch("reading with no request outstanding");
                end else begin
                    want = due_readings.pop_front();
                    if (res_ch.yaw_rate !== want.yaw)
                        report_mismatch($sformatf("yaw_rate got %0d expected %0d",
                                                  res_ch.yaw_rate, want.yaw));
                    if (res_ch.temp_c !== want.temp_c)
                        report_mismatch($sformatf("temp_c got %0d expected %0d",
                                                  res_ch.temp_c, want.temp_c));
                    if (res_ch.cal_phase !== want.phase)
                        report_mismatch($sformatf("cal_phase got %0d expected %0d",
                                                  res_ch.cal_phase, want.phase));
                    if (res_ch.cal_percent !== want.pct)
                        report_mismatch($sformatf("cal_percent got %0d expected %0d",
                                                  res_ch.cal_percent, want.pct));
                    if (res_ch.z_bias !== want.bias)
                        report_mismatch($sformatf("z_bias got %0d expected %0d",
                                                  res_ch.z_bias, want.bias));
                end
            end
            // Hold off for a long stretch now and then so the pipeline backs up
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end else if (accepted_cnt >= next_hold_at && req_ch.valid) begin
                res_ch.ready <= 1'b0;
                hold_left    <= LONG_HOLD;
                next_hold_at <= next_hold_at + 300;
            end else if (recv_stall > 0) begin
                res_ch.ready <= 1'b0;
                recv_stall   <= recv_stall - 1;
            end else if (res_ch.valid && res_ch.ready) begin
                gap = pick_gap(recv_calm);
                res_ch.ready <= (gap == 0);
                recv_stall   <= (gap > 0) ? gap - 1 : 0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic queue_request(logic opc, int gx, int gy, int gz, int tr);
        t_gyro_req rq;
        rq.opcode = opc;
        rq.gx     = gbc_pkg::GYRO_W'(gx);
        rq.gy     = gbc_pkg::GYRO_W'(gy);
        rq.gz     = gbc_pkg::GYRO_W'(gz);
        rq.temp   = gbc_pkg::GYRO_W'(tr);
        pending_requests.push_back(rq);
        queued_cnt++;
    endtask

    // Random value near center that stays inside the motion limit
    function automatic int still_value(int center, int spread);
        int v;
        v = center + rand_in(-spread, spread);
        if (v > motion_lim_cfg) v = motion_lim_cfg;
        if (v < -motion_lim_cfg) v = -motion_lim_cfg;
        if (v > GYRO_TOP) v = GYRO_TOP;
        if (v < GYRO_BOTTOM) v = GYRO_BOTTOM;
        return v;
    endfunction

    // Start plus a run of still samples; a jolt aborts the run partway
    task automatic queue_calibration(int center, int spread, bit jolt);
        int jolt_at, axis, m, v, n;
        jolt_at = (jolt && motion_lim_cfg < 32768) ? rand_in(0, CAL_LEN - 1) : -1;
        n = (jolt_at >= 0) ? jolt_at + 3 : CAL_LEN;
        queue_request(gbc_pkg::OPC_START, int'($urandom), int'($urandom), int'($urandom),
                      int'($urandom));
        for (int i = 0; i < n; i++) begin
            if (i == jolt_at) begin
                axis = int'($urandom_range(0, 2));
                m    = rand_in(motion_lim_cfg + 1, 32768);
                v    = (m == 32768 || $urandom_range(0, 1)) ? -m : m;
                queue_request(gbc_pkg::OPC_SAMPLE,
                              (axis == 0) ? v : still_value(0, motion_lim_cfg),
                              (axis == 1) ? v : still_value(0, motion_lim_cfg),
                              (axis == 2) ? v : still_value(center, spread),
                              int'($urandom));
            end else begin
                queue_request(gbc_pkg::OPC_SAMPLE, still_value(0, motion_lim_cfg),
                              still_value(0, motion_lim_cfg), still_value(center, spread),
                              int'($urandom));
            end
        end
    endtask

    task automatic queue_noise(int n);
        for (int i = 0; i < n; i++)
            queue_request(($urandom_range(0, 9) == 0) ? gbc_pkg::OPC_START
                                                      : gbc_pkg::OPC_SAMPLE,
                          int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    endtask

    // Random mix: mostly clean calibrations, some aborted or cut short, some noise
    task automatic queue_mix(int budget);
        int r, spread;
        queued_cnt = 0;
        while (queued_cnt < budget) begin
            r      = int'($urandom_range(0, 9));
            spread = ($urandom_range(0, 3) == 0) ? motion_lim_cfg : motion_lim_cfg / 16;
            if (r < 6) begin
                queue_calibration(rand_in(-motion_lim_cfg, motion_lim_cfg), spread, 1'b0);
            end else if (r == 6) begin
                queue_calibration(0, spread, 1'b1);
            end else if (r == 7) begin
                queue_request(gbc_pkg::OPC_START, int'($urandom), int'($urandom),
                              int'($urandom), int'($urandom));
                for (int i = rand_in(1, 30); i > 0; i--)
                    queue_request(gbc_pkg::OPC_SAMPLE, still_value(0, motion_lim_cfg),
                                  still_value(0, motion_lim_cfg), still_value(0, spread),
                                  int'($urandom));
            end else begin
                queue_noise(rand_in(1, 5));
            end
        end
    endtask

    // Write both registers back to back while the block is idle
    task automatic set_config(int limit, bit invert);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= gbc_pkg::CFG_MOTION_LIMIT;
        cfg_data <= gbc_pkg::CFG_DATA_W'(limit);
        @(posedge i_clk);
        cfg_idx  <= gbc_pkg::CFG_YAW_INVERT;
        cfg_data <= gbc_pkg::CFG_DATA_W'(invert);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        motion_lim_cfg = limit;
        invert_cfg     = invert;
    endtask

    task automatic wait_quiet();
        while (pending_requests.size() != 0 || req_ch.valid || due_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = gbc_pkg::CFG_MOTION_LIMIT;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.opcode   = gbc_pkg::OPC_SAMPLE;
        req_ch.gyro_x   = '0;
        req_ch.gyro_y   = '0;
        req_ch.gyro_z   = '0;
        req_ch.temp_raw = '0;
        res_ch.ready    = 1'b0;
        motion_lim_cfg  = int'(gbc_pkg::MOTION_LIMIT_RST);
        invert_cfg      = 1'b0;
        track_phase     = gbc_pkg::PH_IDLE;
        taken_samples   = 0;
        z_total         = 0;
        z_offset        = 0;
        mismatch_cnt    = 0;
        send_calm       = 0;
        recv_calm       = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values of the registers: field extremes, threshold edges, restarts
        @(negedge i_clk);
        queue_request(gbc_pkg::OPC_SAMPLE, GYRO_BOTTOM, GYRO_TOP, GYRO_BOTTOM, GYRO_BOTTOM);
        queue_request(gbc_pkg::OPC_SAMPLE, GYRO_TOP, GYRO_BOTTOM, GYRO_TOP, GYRO_TOP);
        queue_request(gbc_pkg::OPC_SAMPLE, 0, 0, 0, 0);
        queue_request(gbc_pkg::OPC_SAMPLE, 0, 0, -1, -12421);
        queue_request(gbc_pkg::OPC_SAMPLE, 0, 0, 1, -12761);
        queue_request(gbc_pkg::OPC_START, GYRO_TOP, GYRO_TOP, GYRO_TOP, GYRO_TOP);
        queue_request(gbc_pkg::OPC_SAMPLE, 3932, -3932, 3932, -12420);
        queue_request(gbc_pkg::OPC_SAMPLE, 0, 0, -3932, 25);
        // restart while running
        queue_request(gbc_pkg::OPC_START, 0, 0, 0, 0);
        queue_request(gbc_pkg::OPC_SAMPLE, 1, 2, 3, 4);
        queue_request(gbc_pkg::OPC_SAMPLE, 0, 0, 3933, 100);
        queue_request(gbc_pkg::OPC_SAMPLE, 5, 5, 5, 5);
        queue_request(gbc_pkg::OPC_START, 0, 0, 0, 0);
        queue_request(gbc_pkg::OPC_SAMPLE, -3933, 0, 0, 0);
        queue_request(gbc_pkg::OPC_START, 0, 0, 0, 0);
        queue_request(gbc_pkg::OPC_SAMPLE, 0, 3933, 0, 0);
        queue_request(gbc_pkg::OPC_START, 0, 0, 0, 0);
        queue_request(gbc_pkg::OPC_SAMPLE, 0, 0, -3933, 0);
        queue_request(gbc_pkg::OPC_SAMPLE, 0, 0, 0, 0);
        queue_calibration(20, 40, 1'b0);
        queue_mix(90);
        wait_quiet();

        // Widest limit with inverted yaw: bias saturates at both ends
        set_config(32768, 1'b1);
        @(negedge i_clk);
        queue_calibration(GYRO_BOTTOM, 0, 1'b0);
        queue_noise(4);
        queue_calibration(GYRO_TOP, 0, 1'b0);
        queue_mix(60);
        wait_quiet();

        // Zero limit: only all-zero samples get through
        set_config(0, 1'b0);
        @(negedge i_clk);
        queue_calibration(0, 0, 1'b0);
        queue_calibration(0, 0, 1'b1);
        queue_noise(20);
        queue_mix(20);
        wait_quiet();

        set_config(rand_in(1, 32767), $urandom_range(0, 1));
        @(negedge i_clk);
        queue_mix(60);
        wait_quiet();

        set_config(int'(gbc_pkg::MOTION_LIMIT_RST), 1'b0);
        @(negedge i_clk);
        queue_mix(60);
        wait_quiet();

        if (mismatch_cnt == 0) begin
            $display("gyro_bias_calibrator test passed");
        end else begin
            $display("gyro_bias_calibrator test failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/gbc_pkg.sv
rtl/gbc_if.sv
rtl/gbc_const_div.sv
rtl/gbc_cal_ctrl.sv
rtl/gyro_bias_calibrator.sv
verif/gyro_bias_calibrator_test.sv
